/* src/fbm_pkg.sv */
package fbm_pkg;

	localparam int CHAR_W             = 16;
	localparam int START_W            = 32;
	localparam int OUT_POS_W          = 32;
	localparam int POSITION_WIDTH_DEF = 32;
	localparam int DEPTH_WIDTH_DEF    = 32;
	localparam int CFG_INDEX_W        = 1;
	localparam int IN_TDATA_W         = 48;
	localparam int OUT_TDATA_W        = 32;

	localparam logic [CHAR_W-1:0] CH_BACKSLASH = 16'h005C;
	localparam logic [CHAR_W-1:0] CH_QUOTE     = 16'h0022;
	localparam logic [CHAR_W-1:0] CH_SQ_OPEN   = 16'h005B;
	localparam logic [CHAR_W-1:0] CH_SQ_CLOSE  = 16'h005D;
	localparam logic [CHAR_W-1:0] CH_CU_OPEN   = 16'h007B;
	localparam logic [CHAR_W-1:0] CH_CU_CLOSE  = 16'h007D;
	localparam logic [CHAR_W-1:0] CH_RD_OPEN   = 16'h0028;
	localparam logic [CHAR_W-1:0] CH_RD_CLOSE  = 16'h0029;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_OPEN_CHAR  = 1'b0,
		REG_CLOSE_CHAR = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_ESCAPE = 2'd1,
		MODE_QUOTE  = 2'd2
	} scan_mode_t;

	typedef struct packed {
		logic [CHAR_W-1:0]  char_code;
		logic               first;
		logic [START_W-1:0] start_position;
		logic               last;
	} item_t;

	typedef struct packed {
		logic                 found;
		logic [OUT_POS_W-1:0] match_position;
	} result_t;

endpackage

/* src/fbm_in_stage.sv */
module fbm_in_stage
	import fbm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  item_valid,
	input  logic  item_take,
	output item_t item
);

	logic  valid_s1;
	item_t item_s1;

	assign in_ready   = !valid_s1 || item_take;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (item_take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

/* src/fbm_scan.sv */
module fbm_scan
	import fbm_pkg::*;
#(
	parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
	parameter int DEPTH_WIDTH    = DEPTH_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  item_t             item,
	input  logic [CHAR_W-1:0] open_char,
	input  logic [CHAR_W-1:0] close_char,
	output logic              res_valid,
	output result_t           res
);

	localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

	scan_mode_t                mode_q;
	logic [CHAR_W-1:0]         open_q;
	logic [CHAR_W-1:0]         close_q;
	logic [DEPTH_WIDTH-1:0]    depth_q;
	logic [POSITION_WIDTH-1:0] pos_q;
	logic                      finished_q;

	logic                      active;
	scan_mode_t                cur_mode;
	logic [CHAR_W-1:0]         cur_open;
	logic [CHAR_W-1:0]         cur_close;
	logic [DEPTH_WIDTH-1:0]    cur_depth;
	logic [POSITION_WIDTH-1:0] cur_pos;
	scan_mode_t                nxt_mode;
	logic [CHAR_W-1:0]         nxt_open;
	logic [CHAR_W-1:0]         nxt_close;
	logic [DEPTH_WIDTH-1:0]    nxt_depth;
	logic [DEPTH_WIDTH-1:0]    dec_depth;
	logic [POSITION_WIDTH-1:0] pos_inc;
	logic [POSITION_WIDTH-1:0] emit_pos;
	logic [POSITION_WIDTH-1:0] pos_hi;
	logic                      emit;
	logic                      hit;
	logic [CHAR_W-1:0]         ch;

	assign ch     = item.char_code;
	assign active = fire && (item.first || !finished_q);

	always_comb begin
		cur_mode  = item.first ? MODE_NORMAL : mode_q;
		cur_open  = item.first ? open_char : open_q;
		cur_close = item.first ? close_char : close_q;
		cur_depth = item.first ? '0 : depth_q;
		cur_pos   = item.first ? POSITION_WIDTH'(item.start_position) : pos_q;

		// saturating increment
		pos_inc   = (cur_pos == POS_MAX) ? cur_pos : cur_pos + 1'b1;
		dec_depth = cur_depth - 1'b1;

		nxt_mode  = cur_mode;
		nxt_open  = cur_open;
		nxt_close = cur_close;
		nxt_depth = cur_depth;
		emit      = 1'b0;
		hit       = 1'b0;
		emit_pos  = '0;

		case (cur_mode)
			MODE_ESCAPE: begin
				nxt_mode = MODE_NORMAL;
			end
			MODE_QUOTE: begin
				if (ch == CH_QUOTE) begin
					nxt_mode = MODE_NORMAL;
				end
			end
			default: begin
				nxt_mode = MODE_NORMAL;
				// pair detection from the first bracket seen
				if (cur_open == '0) begin
					case (ch)
						CH_SQ_OPEN, CH_SQ_CLOSE: begin
							nxt_open  = CH_SQ_OPEN;
							nxt_close = CH_SQ_CLOSE;
						end
						CH_CU_OPEN, CH_CU_CLOSE: begin
							nxt_open  = CH_CU_OPEN;
							nxt_close = CH_CU_CLOSE;
						end
						CH_RD_OPEN, CH_RD_CLOSE: begin
							nxt_open  = CH_RD_OPEN;
							nxt_close = CH_RD_CLOSE;
						end
						default: ;
					endcase
				end
				if (cur_open == '0 && nxt_open != '0 && !item.first) begin
					emit     = 1'b1;
					hit      = 1'b1;
					emit_pos = cur_pos;
				end else if (ch == nxt_open) begin
					nxt_depth = cur_depth + 1'b1;
				end else if (ch == nxt_close) begin
					nxt_depth = dec_depth;
					if (dec_depth == '0) begin
						emit     = 1'b1;
						hit      = 1'b1;
						emit_pos = pos_inc;
					end
				end else if (ch == CH_BACKSLASH) begin
					nxt_mode = MODE_ESCAPE;
				end else if (ch == CH_QUOTE) begin
					nxt_mode = MODE_QUOTE;
				end
			end
		endcase

		if (!emit && item.last) begin
			emit = 1'b1;
		end

		pos_hi = emit_pos >> OUT_POS_W;
	end

	assign res_valid          = active && emit;
	assign res.found          = hit;
	assign res.match_position = (|pos_hi) ? '1 : OUT_POS_W'(emit_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_NORMAL;
			open_q     <= '0;
			close_q    <= '0;
			depth_q    <= '0;
			pos_q      <= '0;
			finished_q <= 1'b1;
		end else if (active) begin
			mode_q     <= nxt_mode;
			open_q     <= nxt_open;
			close_q    <= nxt_close;
			depth_q    <= nxt_depth;
			pos_q      <= pos_inc;
			finished_q <= emit;
		end
	end

endmodule

/* src/fbm_out_stage.sv */
module fbm_out_stage
	import fbm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    res_valid,
	input  result_t res,
	output logic    free,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	logic    valid_q;
	result_t res_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && res_valid) begin
			res_q <= res;
		end
	end

endmodule

/* src/forward_bracket_matcher.sv */
// Forward bracket matcher: scans a stream of 16-bit characters from the item
// marked by tuser (first) and reports, on the master side, the position one
// past the bracket closing the one at the start (tuser = 1), the position of
// the first bracket seen when no pair is configured and it is not the start,
// or not-found (tuser = 0, tdata = 0) when tlast passes unmatched. Backslash
// escapes and double-quoted runs are skipped. One character is taken every
// cycle while the master side does not stall; a request is held in the
// input register while the scan logic works on it, and its result is
// registered in the output stage, which presents it on the master side.
// The scan stage updates depth, position and mode per character, which sets
// the rate of one character per clock. open_char and close_char are taken
// at the start of each search; write them only while the block is idle.
module forward_bracket_matcher
	import fbm_pkg::*;
#(
	parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
	parameter int DEPTH_WIDTH    = DEPTH_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // char_code, start_position
	input  logic                   s_axis_tuser,  // first
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // match_position
	output logic                   m_axis_tuser,  // found
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CHAR_W-1:0]      cfg_data
);

	logic [CHAR_W-1:0] open_char_q;
	logic [CHAR_W-1:0] close_char_q;
	item_t             in_item;
	item_t             item;
	logic              item_valid;
	logic              item_take;
	logic              out_free;
	logic              res_valid;
	result_t           res;
	result_t           out_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_char_q  <= '0;
			close_char_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_OPEN_CHAR:  open_char_q  <= cfg_data;
				REG_CLOSE_CHAR: close_char_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_item.char_code      = s_axis_tdata[CHAR_W-1:0];
	assign in_item.start_position = s_axis_tdata[CHAR_W+START_W-1:CHAR_W];
	assign in_item.first          = s_axis_tuser;
	assign in_item.last           = s_axis_tlast;

	assign item_take = item_valid && out_free;

	fbm_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_item    (in_item),
		.item_valid (item_valid),
		.item_take  (item_take),
		.item       (item)
	);

	fbm_scan #(
		.POSITION_WIDTH (POSITION_WIDTH),
		.DEPTH_WIDTH    (DEPTH_WIDTH)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (item_take),
		.item       (item),
		.open_char  (open_char_q),
		.close_char (close_char_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	fbm_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.free      (out_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = out_res.match_position;
	assign m_axis_tuser = out_res.found;

endmodule

/* src/fbm_checker.sv */
module fbm_checker
	import fbm_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input logic                   s_axis_tuser,
	input logic                   s_axis_tlast,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tuser,
	input logic                   cfg_valid,
	input logic                   cfg_ready,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CHAR_W-1:0]      cfg_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed under stall");

	// not-found carries zero position
	a_nf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("not-found with nonzero position");

	// a result that starts fresh comes from an earlier accepted request
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without matching request");

	// a draining output never blocks the input side
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output drains");

endmodule

bind forward_bracket_matcher fbm_checker u_fbm_checker (.*);
